@@ hdl/celmm_pkg.sv @@
`default_nettype none
package celmm_pkg;

   typedef struct packed {
      logic valid;
      logic last_edge;
      logic no_edges;
   } ctrl_type;

   localparam int unsigned CSR_ADDR_BITS = 3;
   localparam int unsigned CSR_DATA_BITS = 32;
   localparam logic CSR_IDX_TAKE_MINIMUM = 1'b0;
   localparam logic TAKE_MINIMUM_RESET = 1'b1;

endpackage
`default_nettype wire

@@ hdl/celmm_sqrt_cell.sv @@
`default_nettype none
module celmm_sqrt_cell
   import celmm_pkg::*;
#(
   parameter int unsigned ROOT_BITS = 25
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     advance,
   input  wire logic                     in_valid,
   input  wire logic [2*ROOT_BITS-1:0]   in_rad,
   input  wire logic [ROOT_BITS:0]       in_rem,
   input  wire logic [ROOT_BITS-1:0]     in_root,
   output logic                          out_valid,
   output logic [2*ROOT_BITS-1:0]        out_rad,
   output logic [ROOT_BITS:0]            out_rem,
   output logic [ROOT_BITS-1:0]          out_root
);

   localparam int unsigned RAD_BITS = 2 * ROOT_BITS;

   logic                   valid_ff;
   logic [RAD_BITS-1:0]    rad_ff, rad_in;
   logic [ROOT_BITS:0]     rem_ff, rem_in;
   logic [ROOT_BITS-1:0]   root_ff, root_in;
   logic [ROOT_BITS+2:0]   trial_rem;
   logic [ROOT_BITS+2:0]   trial_sub;
   logic [ROOT_BITS+2:0]   trial_diff;
   logic                   digit;

   // one radicand bit pair per cell: rem:pair >= 4*root+1 gives a root bit of 1
   always_comb begin
      trial_rem  = {in_rem, in_rad[RAD_BITS-1 -: 2]};
      trial_sub  = {1'b0, in_root, 2'b01};
      digit      = (trial_rem >= trial_sub);
      trial_diff = trial_rem - trial_sub;
      rad_in     = {in_rad[RAD_BITS-3:0], 2'b00};
      rem_in     = digit ? trial_diff[ROOT_BITS:0] : trial_rem[ROOT_BITS:0];
      root_in    = {in_root[ROOT_BITS-2:0], digit};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rad_ff  <= rad_in;
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_rad   = rad_ff;
   assign out_rem   = rem_ff;
   assign out_root  = root_ff;

endmodule
`default_nettype wire

@@ hdl/celmm_square.sv @@
`default_nettype none
module celmm_square
   import celmm_pkg::*;
#(
   parameter int unsigned COORD_BITS = 24
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          advance,
   input  wire ctrl_type                      in_ctrl,
   input  wire logic signed [COORD_BITS-1:0]  start_x,
   input  wire logic signed [COORD_BITS-1:0]  start_y,
   input  wire logic signed [COORD_BITS-1:0]  start_z,
   input  wire logic signed [COORD_BITS-1:0]  end_x,
   input  wire logic signed [COORD_BITS-1:0]  end_y,
   input  wire logic signed [COORD_BITS-1:0]  end_z,
   output ctrl_type                           out_ctrl,
   output logic [2*COORD_BITS-1:0]            sq_x,
   output logic [2*COORD_BITS-1:0]            sq_y,
   output logic [2*COORD_BITS-1:0]            sq_z
);

   localparam int unsigned SQ_BITS = 2 * COORD_BITS;

   ctrl_type                  ctrl_a_ff, ctrl_b_ff;
   logic [COORD_BITS-1:0]     mag_x_ff, mag_y_ff, mag_z_ff;
   logic [COORD_BITS-1:0]     mag_x_in, mag_y_in, mag_z_in;
   logic [SQ_BITS-1:0]        sq_x_ff, sq_y_ff, sq_z_ff;
   logic signed [COORD_BITS:0] dx, dy, dz;
   logic signed [COORD_BITS:0] nx, ny, nz;

   // |d| never exceeds 2^COORD_BITS - 1, so it fits COORD_BITS bits
   always_comb begin
      dx = $signed({end_x[COORD_BITS-1], end_x}) - $signed({start_x[COORD_BITS-1], start_x});
      dy = $signed({end_y[COORD_BITS-1], end_y}) - $signed({start_y[COORD_BITS-1], start_y});
      dz = $signed({end_z[COORD_BITS-1], end_z}) - $signed({start_z[COORD_BITS-1], start_z});
      nx = -dx;
      ny = -dy;
      nz = -dz;
      mag_x_in = dx[COORD_BITS] ? nx[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
      mag_y_in = dy[COORD_BITS] ? ny[COORD_BITS-1:0] : dy[COORD_BITS-1:0];
      mag_z_in = dz[COORD_BITS] ? nz[COORD_BITS-1:0] : dz[COORD_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_a_ff <= '0;
         ctrl_b_ff <= '0;
      end else if (advance) begin
         ctrl_a_ff <= in_ctrl;
         ctrl_b_ff <= ctrl_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mag_x_ff <= mag_x_in;
         mag_y_ff <= mag_y_in;
         mag_z_ff <= mag_z_in;
         sq_x_ff  <= mag_x_ff * mag_x_ff;
         sq_y_ff  <= mag_y_ff * mag_y_ff;
         sq_z_ff  <= mag_z_ff * mag_z_ff;
      end
   end

   assign out_ctrl = ctrl_b_ff;
   assign sq_x     = sq_x_ff;
   assign sq_y     = sq_y_ff;
   assign sq_z     = sq_z_ff;

endmodule
`default_nettype wire

@@ hdl/celmm_keep.sv @@
`default_nettype none
module celmm_keep
   import celmm_pkg::*;
#(
   parameter int unsigned COORD_BITS = 24
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        advance,
   input  wire logic                        take_minimum,
   input  wire ctrl_type                    in_ctrl,
   input  wire logic [2*COORD_BITS-1:0]     sq_x,
   input  wire logic [2*COORD_BITS-1:0]     sq_y,
   input  wire logic [2*COORD_BITS-1:0]     sq_z,
   output logic                             out_valid,
   output logic [2*COORD_BITS+1:0]          out_square
);

   localparam int unsigned BEST_BITS = 2 * COORD_BITS + 2;

   logic [BEST_BITS-1:0] best_ff, best_in;
   logic                 open_ff, open_in;
   logic                 valid_ff, valid_in;
   logic [BEST_BITS-1:0] square_ff, square_in;
   logic [BEST_BITS-1:0] sum;
   logic                 pick;

   always_comb begin
      sum = {2'b00, sq_x} + {2'b00, sq_y} + {2'b00, sq_z};
      pick = !open_ff || (take_minimum ? (sum < best_ff) : (sum > best_ff));
      best_in   = best_ff;
      open_in   = open_ff;
      valid_in  = 1'b0;
      square_in = best_ff;
      if (in_ctrl.valid) begin
         if (in_ctrl.no_edges) begin
            // vertex: drop any open cell, report zero
            best_in   = '0;
            open_in   = 1'b0;
            valid_in  = 1'b1;
            square_in = '0;
         end else begin
            best_in   = pick ? sum : best_ff;
            open_in   = !in_ctrl.last_edge;
            valid_in  = in_ctrl.last_edge;
            square_in = best_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_ff  <= '0;
         open_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else if (advance) begin
         best_ff  <= best_in;
         open_ff  <= open_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         square_ff <= square_in;
      end
   end

   assign out_valid  = valid_ff;
   assign out_square = square_ff;

endmodule
`default_nettype wire

@@ hdl/cell_edge_length_min_max.sv @@
// Shortest or longest edge of a mesh cell. Edges stream in one transaction per cycle
// while the pipeline advances. Each cell's result (floor square root of the kept
// squared length, 0 for a vertex cell) goes through registered axis magnitudes,
// squares, the min/max keep and a chain of COORD_BITS+1 square-root cells that each
// settle one root bit. The whole pipeline advances together, so a stalled rsp_ready
// holds req_ready low in the same cycle. take_minimum (reset 1) sits at byte address
// 0; the user must write it only while idle, and the block has no check for this.
`default_nettype none
module cell_edge_length_min_max
   import celmm_pkg::*;
#(
   parameter int unsigned COORD_BITS = 24
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic signed [COORD_BITS-1:0]  req_start_x,
   input  wire logic signed [COORD_BITS-1:0]  req_start_y,
   input  wire logic signed [COORD_BITS-1:0]  req_start_z,
   input  wire logic signed [COORD_BITS-1:0]  req_end_x,
   input  wire logic signed [COORD_BITS-1:0]  req_end_y,
   input  wire logic signed [COORD_BITS-1:0]  req_end_z,
   input  wire logic                          req_cell_has_no_edges,
   input  wire logic                          req_last_edge,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [COORD_BITS:0]                rsp_edge_length,
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [CSR_ADDR_BITS-1:0]      paddr,
   input  wire logic [CSR_DATA_BITS-1:0]      pwdata,
   output logic [CSR_DATA_BITS-1:0]           prdata,
   output logic                               pready
);

   localparam int unsigned ROOT_BITS = COORD_BITS + 1;
   localparam int unsigned RAD_BITS  = 2 * ROOT_BITS;

   logic                 take_minimum_ff, take_minimum_in;
   logic                 advance;
   logic                 csr_hit;
   ctrl_type             req_ctrl, sq_ctrl;
   logic [2*COORD_BITS-1:0] sq_x, sq_y, sq_z;
   logic                 keep_valid;
   logic [RAD_BITS-1:0]  keep_square;

   logic                 link_valid [ROOT_BITS+1];
   logic [RAD_BITS-1:0]  link_rad   [ROOT_BITS+1];
   logic [ROOT_BITS:0]   link_rem   [ROOT_BITS+1];
   logic [ROOT_BITS-1:0] link_root  [ROOT_BITS+1];

   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   // configuration
   assign pready  = 1'b1;
   assign csr_hit = (paddr[CSR_ADDR_BITS-1] == CSR_IDX_TAKE_MINIMUM);

   always_comb begin
      take_minimum_in = take_minimum_ff;
      if (psel && penable && pwrite && pready && csr_hit) begin
         take_minimum_in = pwdata[0];
      end
      prdata = '0;
      if (csr_hit) begin
         prdata[0] = take_minimum_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         take_minimum_ff <= TAKE_MINIMUM_RESET;
      end else begin
         take_minimum_ff <= take_minimum_in;
      end
   end

   always_comb begin
      req_ctrl.valid     = req_valid;
      req_ctrl.last_edge = req_last_edge;
      req_ctrl.no_edges  = req_cell_has_no_edges;
   end

   celmm_square #(
      .COORD_BITS(COORD_BITS)
   ) u_square (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .in_ctrl (req_ctrl),
      .start_x (req_start_x),
      .start_y (req_start_y),
      .start_z (req_start_z),
      .end_x   (req_end_x),
      .end_y   (req_end_y),
      .end_z   (req_end_z),
      .out_ctrl(sq_ctrl),
      .sq_x    (sq_x),
      .sq_y    (sq_y),
      .sq_z    (sq_z)
   );

   celmm_keep #(
      .COORD_BITS(COORD_BITS)
   ) u_keep (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .take_minimum(take_minimum_ff),
      .in_ctrl     (sq_ctrl),
      .sq_x        (sq_x),
      .sq_y        (sq_y),
      .sq_z        (sq_z),
      .out_valid   (keep_valid),
      .out_square  (keep_square)
   );

   assign link_valid[0] = keep_valid;
   assign link_rad[0]   = keep_square;
   assign link_rem[0]   = '0;
   assign link_root[0]  = '0;

   for (genvar i = 0; i < ROOT_BITS; i++) begin : g_root
      celmm_sqrt_cell #(
         .ROOT_BITS(ROOT_BITS)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .in_valid (link_valid[i]),
         .in_rad   (link_rad[i]),
         .in_rem   (link_rem[i]),
         .in_root  (link_root[i]),
         .out_valid(link_valid[i+1]),
         .out_rad  (link_rad[i+1]),
         .out_rem  (link_rem[i+1]),
         .out_root (link_root[i+1])
      );
   end

   assign rsp_valid       = link_valid[ROOT_BITS];
   assign rsp_edge_length = link_root[ROOT_BITS];

endmodule
`default_nettype wire

@@ hdl/celmm_checker.sv @@
`default_nettype none
module celmm_checker
   import celmm_pkg::*;
#(
   parameter int unsigned COORD_BITS = 24
) (
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      req_ready,
   input wire logic                      rsp_valid,
   input wire logic                      rsp_ready,
   input wire logic [COORD_BITS:0]       rsp_edge_length,
   input wire logic                      psel,
   input wire logic                      penable,
   input wire logic                      pwrite,
   input wire logic [CSR_ADDR_BITS-1:0]  paddr,
   input wire logic [CSR_DATA_BITS-1:0]  pwdata,
   input wire logic [CSR_DATA_BITS-1:0]  prdata,
   input wire logic                      pready
);

   // a held result keeps its value until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_edge_length))
      else $error("result changed while stalled");

   // an empty output stage never blocks the input
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with no result pending");

   // nothing is in flight straight after reset
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // mode register reads back what was written
   a_mode_readback: assert property (@(posedge clock) disable iff (reset)
      psel && penable && pwrite && pready && (paddr[CSR_ADDR_BITS-1] == CSR_IDX_TAKE_MINIMUM)
      |=> (prdata[0] == $past(pwdata[0])) || (paddr[CSR_ADDR_BITS-1] != CSR_IDX_TAKE_MINIMUM))
      else $error("take_minimum readback mismatch");

endmodule

bind cell_edge_length_min_max celmm_checker #(
   .COORD_BITS(COORD_BITS)
) u_celmm_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_edge_length(rsp_edge_length),
   .psel           (psel),
   .penable        (penable),
   .pwrite         (pwrite),
   .paddr          (paddr),
   .pwdata         (pwdata),
   .prdata         (prdata),
   .pready         (pready)
);
`default_nettype wire
